// File: hw/rtl/pmss_pkg.sv
// Shared types and constants of the priority message slot store.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pmss_pkg;

  localparam int unsigned DEF_SLOTS  = 16;
  localparam int unsigned DEF_QUEUES = 2;

  localparam int unsigned PRIO_W     = 32;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned QID_W      = 1;
  localparam int unsigned TSLOT_W    = 4;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned OCC_W      = 5;

  // -1.0 in Q16.16 marks an empty slot
  localparam logic signed [PRIO_W-1:0] PRIO_EMPTY = 32'shFFFF_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAVE   = 2'd0,
    CMD_GET    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED   = 3'd0,
    STAT_REPLACED = 3'd1,
    STAT_REJECTED = 3'd2,
    STAT_FOUND    = 3'd3,
    STAT_EMPTYQ   = 3'd4,
    STAT_DELETED  = 3'd5
  } status_e;

  // Control of the shared scan comparator
  typedef struct packed {
    logic en;        // a read word is valid this cycle
    logic find_max;  // 1: keep highest, 0: keep lowest and stop at empty
  } scan_ctl_t;

endpackage

// File: hw/rtl/pmss_cmd_if.sv
// Command channel of the slot store: valid/ready plus one command word.
// Depends on pmss_pkg for field widths.
`timescale 1ns / 1ps

interface pmss_cmd_if;
  import pmss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [QID_W-1:0]         queue_id;
  logic signed [PRIO_W-1:0] new_priority;
  logic [TSLOT_W-1:0]       target_slot;

  modport source (output valid, cmd, queue_id, new_priority, target_slot, input ready);
  modport sink   (input valid, cmd, queue_id, new_priority, target_slot, output ready);

endinterface

// File: hw/rtl/pmss_rsp_if.sv
// Result channel of the slot store: valid/ready plus one result word.
// Depends on pmss_pkg for field widths.
`timescale 1ns / 1ps

interface pmss_rsp_if;
  import pmss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SLOT_OUT_W-1:0] slot;
  logic [STATUS_W-1:0]   status;
  logic [OCC_W-1:0]      occupied;

  modport source (output valid, slot, status, occupied, input ready);
  modport sink   (input valid, slot, status, occupied, output ready);

endinterface

// File: hw/rtl/pmss_slot_mem.sv
// Priority table of all queues: one write port, one registered read port.
// Depends on pmss_pkg for the priority width.
`timescale 1ns / 1ps

module pmss_slot_mem #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [ADDR_W-1:0]                waddr_i,
  input  logic signed [pmss_pkg::PRIO_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]                raddr_i,
  output logic signed [pmss_pkg::PRIO_W-1:0] rdata_o
);
  import pmss_pkg::*;

  logic signed [PRIO_W-1:0] mem [DEPTH];
  logic signed [PRIO_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/pmss_scan_unit.sv
// Shared compare unit: keeps the best priority and its slot over a scan.
// Depends on pmss_pkg for scan_ctl_t and the priority width.
`timescale 1ns / 1ps

module pmss_scan_unit #(
  parameter int unsigned SLOT_W = 4
) (
  input  logic                               clk_i,
  input  pmss_pkg::scan_ctl_t                ctl_i,
  input  logic [SLOT_W-1:0]                  idx_i,
  input  logic signed [pmss_pkg::PRIO_W-1:0] prio_i,
  output logic signed [pmss_pkg::PRIO_W-1:0] best_prio_o,
  output logic [SLOT_W-1:0]                  best_idx_o
);
  import pmss_pkg::*;

  logic signed [PRIO_W-1:0] best_q, best_d;
  logic [SLOT_W-1:0]        idx_q, idx_d;
  logic signed [PRIO_W-1:0] op_a, op_b;
  logic                     better;
  logic                     take;

  // one comparator: swap operands between min and max search
  assign op_a   = ctl_i.find_max ? best_q : prio_i;
  assign op_b   = ctl_i.find_max ? prio_i : best_q;
  assign better = op_a < op_b;

  always_comb begin
    // first slot always loads; a min search freezes once an empty slot is held
    take   = ctl_i.en && ((idx_i == '0) ||
                          (better && (ctl_i.find_max || !best_q[PRIO_W-1])));
    best_d = take ? prio_i : best_q;
    idx_d  = take ? idx_i : idx_q;
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    idx_q  <= idx_d;
  end

  assign best_prio_o = best_q;
  assign best_idx_o  = idx_q;

endmodule

// File: hw/rtl/priority_message_slot_store.sv
// Priority message slot store: per-queue slot tables of Q16.16 priorities.
// Save and get on a valid queue scan one slot per cycle, then pass through S_LAST and S_RESULT.
// Delete and other commands go from accept straight to S_RESULT. One command in flight at a time;
// a new command is taken while the previous result waits in the output register.
// After reset a clearing pass marks every slot of every queue empty,
// and no command is taken until it ends. Counts reset to zero at once.
`timescale 1ns / 1ps

module priority_message_slot_store #(
  parameter int unsigned SLOTS  = pmss_pkg::DEF_SLOTS,
  parameter int unsigned QUEUES = pmss_pkg::DEF_QUEUES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pmss_cmd_if.sink          req_i,
  pmss_rsp_if.source        rsp_o
);
  import pmss_pkg::*;

  localparam int unsigned DEPTH  = QUEUES * SLOTS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned Q_W    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_RESULT
  } state_e;

  state_e                   state_q, state_d;
  logic [ADDR_W-1:0]        clr_idx_q, clr_idx_d;
  logic [SLOT_W-1:0]        issue_idx_q, issue_idx_d;
  logic [SLOT_W-1:0]        data_idx_q, data_idx_d;
  logic                     data_vld_q, data_vld_d;
  logic [CMD_W-1:0]         cmd_q, cmd_d;
  logic [Q_W-1:0]           qid_q, qid_d;
  logic                     q_ok_q, q_ok_d;
  logic signed [PRIO_W-1:0] prio_q, prio_d;
  logic [TSLOT_W-1:0]       target_q, target_d;
  logic [CNT_W-1:0]         occ_q [QUEUES];
  logic [CNT_W-1:0]         occ_d [QUEUES];
  logic                     rsp_valid_q, rsp_valid_d;
  logic [SLOT_OUT_W-1:0]    rsp_slot_q, rsp_slot_d;
  logic [STATUS_W-1:0]      rsp_status_q, rsp_status_d;
  logic [OCC_W-1:0]         rsp_occ_q, rsp_occ_d;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [PRIO_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]        mem_raddr;
  logic signed [PRIO_W-1:0] mem_rdata;
  logic [ADDR_W-1:0]        base_addr;

  scan_ctl_t                scan_ctl;
  logic signed [PRIO_W-1:0] best_prio;
  logic [SLOT_W-1:0]        best_idx;

  logic [CNT_W-1:0]         cnt_cur;
  logic                     cmd_scans;
  logic                     issue_last;
  logic                     clr_last;

  assign base_addr  = ADDR_W'(qid_q) * ADDR_W'(SLOTS);
  assign mem_raddr  = base_addr + ADDR_W'(issue_idx_q);
  assign issue_last = issue_idx_q == SLOT_W'(SLOTS - 1);
  assign clr_last   = clr_idx_q == ADDR_W'(DEPTH - 1);
  assign cnt_cur    = q_ok_q ? occ_q[qid_q] : '0;
  assign cmd_scans  = (cmd_e'(req_i.cmd) == CMD_SAVE) || (cmd_e'(req_i.cmd) == CMD_GET);

  assign scan_ctl.en       = data_vld_q;
  assign scan_ctl.find_max = cmd_e'(cmd_q) == CMD_GET;

  pmss_slot_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pmss_scan_unit #(
    .SLOT_W (SLOT_W)
  ) u_scan (
    .clk_i       (clk_i),
    .ctl_i       (scan_ctl),
    .idx_i       (data_idx_q),
    .prio_i      (mem_rdata),
    .best_prio_o (best_prio),
    .best_idx_o  (best_idx)
  );

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    issue_idx_d  = issue_idx_q;
    cmd_d        = cmd_q;
    qid_d        = qid_q;
    q_ok_d       = q_ok_q;
    prio_d       = prio_q;
    target_d     = target_q;
    occ_d        = occ_q;
    rsp_slot_d   = rsp_slot_q;
    rsp_status_d = rsp_status_q;
    rsp_occ_d    = rsp_occ_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    data_vld_d   = state_q == S_SCAN;
    data_idx_d   = issue_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_idx_q;
    mem_wdata    = PRIO_EMPTY;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_last) begin
          state_d = S_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d       = req_i.cmd;
          qid_d       = Q_W'(req_i.queue_id);
          q_ok_d      = int'(req_i.queue_id) < QUEUES;
          prio_d      = req_i.new_priority;
          target_d    = req_i.target_slot;
          issue_idx_d = '0;
          state_d     = ((int'(req_i.queue_id) < QUEUES) && cmd_scans) ? S_SCAN : S_RESULT;
        end
      end
      S_SCAN: begin
        if (issue_last) begin
          state_d = S_LAST;
        end else begin
          issue_idx_d = issue_idx_q + 1'b1;
        end
      end
      S_LAST: begin
        // last read word goes through the compare unit
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_slot_d   = '0;
          rsp_status_d = STAT_REJECTED;
          rsp_occ_d    = OCC_W'(cnt_cur);
          state_d      = S_IDLE;
          if (q_ok_q) begin
            unique case (cmd_e'(cmd_q))
              CMD_SAVE: begin
                rsp_slot_d = SLOT_OUT_W'(best_idx);
                if (prio_q > best_prio) begin
                  mem_we    = 1'b1;
                  mem_waddr = base_addr + ADDR_W'(best_idx);
                  mem_wdata = prio_q;
                  if (best_prio[PRIO_W-1]) begin
                    rsp_status_d = STAT_STORED;
                    if (cnt_cur < CNT_W'(SLOTS)) begin
                      occ_d[qid_q] = cnt_cur + 1'b1;
                      rsp_occ_d    = OCC_W'(cnt_cur + 1'b1);
                    end
                  end else begin
                    rsp_status_d = STAT_REPLACED;
                  end
                end
              end
              CMD_GET: begin
                if (cnt_cur == '0) begin
                  rsp_status_d = STAT_EMPTYQ;
                end else begin
                  rsp_slot_d   = SLOT_OUT_W'(best_idx);
                  rsp_status_d = STAT_FOUND;
                end
              end
              CMD_DELETE: begin
                if (int'(target_q) < SLOTS) begin
                  mem_we       = 1'b1;
                  mem_waddr    = base_addr + ADDR_W'(SLOT_W'(target_q));
                  mem_wdata    = PRIO_EMPTY;
                  rsp_slot_d   = target_q;
                  rsp_status_d = STAT_DELETED;
                  if (cnt_cur != '0) begin
                    occ_d[qid_q] = cnt_cur - 1'b1;
                    rsp_occ_d    = OCC_W'(cnt_cur - 1'b1);
                  end
                end
              end
              CMD_NOP: begin
                rsp_status_d = STAT_REJECTED;
              end
            endcase
          end else begin
            rsp_occ_d = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_idx_q    <= '0;
      issue_idx_q  <= '0;
      data_idx_q   <= '0;
      data_vld_q   <= 1'b0;
      cmd_q        <= '0;
      qid_q        <= '0;
      q_ok_q       <= 1'b0;
      prio_q       <= '0;
      target_q     <= '0;
      occ_q        <= '{default: '0};
      rsp_valid_q  <= 1'b0;
      rsp_slot_q   <= '0;
      rsp_status_q <= '0;
      rsp_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      clr_idx_q    <= clr_idx_d;
      issue_idx_q  <= issue_idx_d;
      data_idx_q   <= data_idx_d;
      data_vld_q   <= data_vld_d;
      cmd_q        <= cmd_d;
      qid_q        <= qid_d;
      q_ok_q       <= q_ok_d;
      prio_q       <= prio_d;
      target_q     <= target_d;
      occ_q        <= occ_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_slot_q   <= rsp_slot_d;
      rsp_status_q <= rsp_status_d;
      rsp_occ_q    <= rsp_occ_d;
    end
  end

  assign req_i.ready    = state_q == S_IDLE;
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.slot     = rsp_slot_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.occupied = rsp_occ_q;

endmodule
